// File: rtl/core/bfa_pkg.sv
// bfa_pkg: shared widths, operation and status codes, and the list search
// result type of the buddy frame allocator. No dependencies.
`default_nettype none

package bfa_pkg;

  localparam int DEF_NUM_FRAMES = 65536;
  localparam int DEF_MAX_ORDER  = 10;

  localparam int MODE_W   = 3;
  localparam int FRAME_W  = 16;
  localparam int ORDER_W  = 4;
  localparam int STATUS_W = 2;
  localparam int REF_W    = 16;
  localparam int TOTAL_W  = 17;
  localparam int HEAD_W   = 5;

  // head word: valid bit and order; a cleared valid bit marks "not a free head"
  localparam logic [HEAD_W-1:0] NOT_HEAD = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 3'd0,
    MODE_FREE  = 3'd1,
    MODE_SHARE = 3'd2,
    MODE_QUERY = 3'd3,
    MODE_ADD   = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef struct packed {
    logic               any;
    logic [ORDER_W-1:0] found;
  } head_srch_t;

endpackage

`default_nettype wire

// File: rtl/core/bfa_if.sv
// bfa_req_if / bfa_rsp_if: valid/ready channels of the buddy frame allocator.
// Depends on bfa_pkg for field widths.
`default_nettype none

interface bfa_req_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FRAME_W-1:0] frame_index;
  logic [ORDER_W-1:0] block_order;
  modport source (output valid, mode, frame_index, block_order, input ready);
  modport sink (input valid, mode, frame_index, block_order, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  result_frame;
  logic                released;
  logic [REF_W-1:0]    frame_refs;
  logic [TOTAL_W-1:0]  free_count;
  logic [TOTAL_W-1:0]  usable_frames;
  modport source (output valid, status, result_frame, released, frame_refs, free_count,
                  usable_frames, input ready);
  modport sink (input valid, status, result_frame, released, frame_refs, free_count,
                usable_frames, output ready);
endinterface

`default_nettype wire

// File: rtl/core/buddy_frame_allocator_refcount.sv
// Buddy frame allocator with per-frame reference counts: top level sequencer.
// Uses bfa_pkg, bfa_req_if/bfa_rsp_if, bfa_ram (four instances) and bfa_heads.
//
// Usage: one request transaction on req (mode, frame_index, block_order) yields
// exactly one response transaction on rsp. Operations run one at a time; req is
// ready only while the sequencer is idle. State lives in rams with one write port
// and one registered read port, so each operation runs as a sequence of states;
// alloc and free walk the refcount ram one frame per step over the whole block.
// After rst a clearing pass writes every refcount to one and every head marker
// to not-a-head, during which req is not ready.
// The response sits in an output register; a stall on rsp holds the finished
// result there and a new request is still taken meanwhile, finishing only as
// far as its own response stage.
`default_nettype none

module buddy_frame_allocator_refcount #(
  parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
  parameter int MAX_ORDER  = bfa_pkg::DEF_MAX_ORDER
) (
  input  logic         clk,
  input  logic         rst,
  bfa_req_if.sink      req,
  bfa_rsp_if.source    rsp
);
  import bfa_pkg::*;

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int LW = FW + 1;
  localparam int XW = ((FW > FRAME_W) ? FW : FRAME_W) + 1;
  localparam int CW = MAX_ORDER + 1;
  localparam logic [XW-1:0]      NF        = XW'(NUM_FRAMES);
  localparam logic [FW-1:0]      LAST      = FW'(NUM_FRAMES - 1);
  localparam logic [ORDER_W-1:0] MAXO      = ORDER_W'(MAX_ORDER);
  localparam logic [LW-1:0]      NULL_LINK = {1'b1, {FW{1'b0}}};

  typedef enum logic [17:0] {
    S_CLEAR  = 18'h00001,
    S_IDLE   = 18'h00002,
    S_START  = 18'h00004,
    S_ALCRD  = 18'h00008,
    S_UNLINK = 18'h00010,
    S_SPLIT  = 18'h00020,
    S_PUSH1  = 18'h00040,
    S_PUSH2  = 18'h00080,
    S_SETREF = 18'h00100,
    S_DECRD  = 18'h00200,
    S_DECWR  = 18'h00400,
    S_MRGCHK = 18'h00800,
    S_MRGTST = 18'h01000,
    S_SHRD   = 18'h02000,
    S_SHWR   = 18'h04000,
    S_REFRD  = 18'h08000,
    S_REFWT  = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  state_t state;

  // transaction registers
  logic [MODE_W-1:0]   mode_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [ORDER_W-1:0]  ord_q;
  logic [XW-1:0]       base;
  logic [ORDER_W-1:0]  cur_ord;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       size_m1;
  logic                nz;
  logic [FW-1:0]       uf;
  logic [FW-1:0]       pf;
  logic [LW-1:0]       hsave;
  logic [FW-1:0]       clr;
  logic [STATUS_W-1:0] st;
  logic [FRAME_W-1:0]  res;
  logic                rel;
  logic [REF_W-1:0]    refs;
  logic [TOTAL_W-1:0]  free_total;
  logic [TOTAL_W-1:0]  usable_total;

  // response register
  logic                out_valid;
  logic [STATUS_W-1:0] o_status;
  logic [FRAME_W-1:0]  o_result;
  logic                o_released;
  logic [REF_W-1:0]    o_refs;
  logic [TOTAL_W-1:0]  o_free;
  logic [TOTAL_W-1:0]  o_usable;

  // memory ports
  logic              ref_we, head_we, next_we, prev_we;
  logic [FW-1:0]     ref_wa, ref_ra, head_wa, head_ra, next_wa, prev_wa, link_ra;
  logic [REF_W-1:0]  ref_wd, ref_rd;
  logic [HEAD_W-1:0] head_wd, head_rd;
  logic [LW-1:0]     next_wd, next_rd, prev_wd, prev_rd;

  logic              hd_we;
  logic [LW-1:0]     hd_wd, hd_rd;
  head_srch_t        srch;

  // address arithmetic
  logic [XW-1:0]      frame_x, ord_bit, fbase, fend, buddy, half, ref_addr;
  logic               in_range, head_match, nz_all, do_unlink;
  logic [ORDER_W-1:0] split_ord;
  logic [CW:0]        sz_full;
  logic [TOTAL_W-1:0] size17;
  logic [REF_W-1:0]   ref_dec;
  state_t             push_ret;

  // decode of a new transaction
  logic [STATUS_W-1:0] start_st;
  state_t              start_state;

  assign frame_x    = XW'(frame_q);
  assign in_range   = frame_x < NF;
  assign ord_bit    = XW'(1) << ord_q;
  assign fbase      = frame_x & ~(ord_bit - XW'(1));
  assign fend       = fbase + ord_bit;
  assign buddy      = base ^ (XW'(1) << cur_ord);
  assign split_ord  = cur_ord - ORDER_W'(1);
  assign half       = base + (XW'(1) << split_ord);
  assign ref_addr   = base + XW'(cnt);
  assign head_match = head_rd == {1'b1, cur_ord};
  assign ref_dec    = ref_rd - REF_W'(1);
  assign nz_all     = nz || (ref_dec != '0);
  assign sz_full    = (CW + 1)'(1) << ord_q;
  assign size17     = TOTAL_W'(size_m1) + TOTAL_W'(1);
  assign push_ret   = (mode_q == MODE_ALLOC) ? S_SPLIT : S_REFRD;
  assign do_unlink  = (state == S_UNLINK) || (state == S_MRGTST && head_match);

  bfa_ram #(.W(REF_W), .DEPTH(NUM_FRAMES)) u_ref_ram (
    .clk(clk), .we(ref_we), .wa(ref_wa), .wd(ref_wd), .ra(ref_ra), .rd(ref_rd)
  );

  bfa_ram #(.W(HEAD_W), .DEPTH(NUM_FRAMES)) u_head_ram (
    .clk(clk), .we(head_we), .wa(head_wa), .wd(head_wd), .ra(head_ra), .rd(head_rd)
  );

  bfa_ram #(.W(LW), .DEPTH(NUM_FRAMES)) u_next_ram (
    .clk(clk), .we(next_we), .wa(next_wa), .wd(next_wd), .ra(link_ra), .rd(next_rd)
  );

  bfa_ram #(.W(LW), .DEPTH(NUM_FRAMES)) u_prev_ram (
    .clk(clk), .we(prev_we), .wa(prev_wa), .wd(prev_wd), .ra(link_ra), .rd(prev_rd)
  );

  bfa_heads #(.FW(FW), .MAX_ORDER(MAX_ORDER)) u_heads (
    .clk(clk), .rst(rst), .we(hd_we), .idx(cur_ord), .wdata(hd_wd), .rdata(hd_rd),
    .req_ord(ord_q), .srch(srch)
  );

  always_comb begin
    start_st    = ST_OK;
    start_state = S_DONE;
    case (mode_q)
      MODE_ALLOC: begin
        if (ord_q > MAXO) begin
          start_st = ST_ORDER;
        end else if (!srch.any) begin
          start_st = ST_NOMEM;
        end else begin
          start_state = S_ALCRD;
        end
      end
      MODE_FREE: begin
        if (ord_q > MAXO) begin
          start_st = ST_ORDER;
          if (in_range) start_state = S_REFRD;
        end else if (fend > NF) begin
          if (in_range) start_state = S_REFRD;
        end else begin
          start_state = S_DECRD;
        end
      end
      MODE_SHARE: begin
        if (in_range) start_state = S_SHRD;
      end
      MODE_QUERY: begin
        if (in_range) start_state = S_REFRD;
      end
      MODE_ADD: begin
        if (in_range) start_state = S_DECRD;
      end
      default: ;
    endcase
  end

  always_comb begin
    ref_we  = 1'b0;
    head_we = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    hd_we   = 1'b0;
    ref_wa  = ref_addr[FW-1:0];
    ref_wd  = ref_dec;
    ref_ra  = (state == S_DECRD) ? ref_addr[FW-1:0] : frame_x[FW-1:0];
    head_ra = buddy[FW-1:0];
    link_ra = (state == S_ALCRD) ? hd_rd[FW-1:0] : buddy[FW-1:0];
    head_wa = pf;
    head_wd = {1'b1, cur_ord};
    next_wa = pf;
    next_wd = hd_rd;
    prev_wa = pf;
    prev_wd = NULL_LINK;
    hd_wd   = {1'b0, pf};
    case (state)
      S_CLEAR: begin
        ref_we  = 1'b1;
        ref_wa  = clr;
        ref_wd  = REF_W'(1);
        head_we = 1'b1;
        head_wa = clr;
        head_wd = NOT_HEAD;
      end
      S_DECWR: begin
        ref_we = 1'b1;
      end
      S_SETREF: begin
        ref_we = ref_addr < NF;
        ref_wd = REF_W'(1);
      end
      S_SHWR: begin
        ref_we = 1'b1;
        ref_wa = frame_x[FW-1:0];
        ref_wd = ref_rd + REF_W'(1);
      end
      S_PUSH1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        head_we = 1'b1;
        hd_we   = 1'b1;
      end
      S_PUSH2: begin
        prev_we = 1'b1;
        prev_wa = hsave[FW-1:0];
        prev_wd = {1'b0, pf};
      end
      default: ;
    endcase
    // unlink uf from the list of order cur_ord
    if (do_unlink) begin
      if (!prev_rd[LW-1]) begin
        next_we = 1'b1;
        next_wa = prev_rd[FW-1:0];
        next_wd = next_rd;
      end else begin
        hd_we = 1'b1;
        hd_wd = next_rd;
      end
      if (!next_rd[LW-1]) begin
        prev_we = 1'b1;
        prev_wa = next_rd[FW-1:0];
        prev_wd = prev_rd;
      end
      head_we = 1'b1;
      head_wa = uf;
      head_wd = NOT_HEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      out_valid    <= 1'b0;
      free_total   <= '0;
      usable_total <= '0;
    end else begin
      // the done state reloads the response register itself
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + FW'(1);
          if (clr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            mode_q  <= req.mode;
            frame_q <= req.frame_index;
            ord_q   <= req.block_order;
            state   <= S_START;
          end
        end
        S_START: begin
          st      <= start_st;
          res     <= '0;
          rel     <= 1'b0;
          refs    <= '0;
          cnt     <= '0;
          nz      <= 1'b0;
          size_m1 <= (mode_q == MODE_ADD) ? '0 : CW'(sz_full - (CW + 1)'(1));
          state   <= start_state;
          case (mode_q)
            MODE_ALLOC: begin
              cur_ord <= srch.found;
            end
            MODE_FREE: begin
              base    <= fbase;
              cur_ord <= ord_q;
            end
            MODE_ADD: begin
              if (in_range) begin
                base         <= frame_x;
                cur_ord      <= '0;
                usable_total <= usable_total + TOTAL_W'(1);
              end
            end
            default: ;
          endcase
        end
        S_ALCRD: begin
          base  <= XW'(hd_rd[FW-1:0]);
          uf    <= hd_rd[FW-1:0];
          state <= S_UNLINK;
        end
        S_UNLINK: begin
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          if (cur_ord > ord_q) begin
            cur_ord <= split_ord;
            // upper half goes back on the list one order down
            if (half < NF) begin
              pf    <= half[FW-1:0];
              state <= S_PUSH1;
            end
          end else begin
            cnt   <= '0;
            state <= S_SETREF;
          end
        end
        S_PUSH1: begin
          hsave <= hd_rd;
          rel   <= mode_q != MODE_ALLOC;
          state <= hd_rd[LW-1] ? push_ret : S_PUSH2;
        end
        S_PUSH2: begin
          state <= push_ret;
        end
        S_SETREF: begin
          if (cnt == size_m1) begin
            free_total <= free_total - size17;
            res        <= base[FRAME_W-1:0];
            refs       <= REF_W'(1);
            state      <= S_DONE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DECRD: begin
          state <= S_DECWR;
        end
        S_DECWR: begin
          nz <= nz_all;
          if (cnt == size_m1) begin
            if (nz_all) begin
              state <= S_REFRD;
            end else begin
              free_total <= free_total + size17;
              state      <= S_MRGCHK;
            end
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_DECRD;
          end
        end
        S_MRGCHK: begin
          if (cur_ord < MAXO && buddy < NF) begin
            uf    <= buddy[FW-1:0];
            state <= S_MRGTST;
          end else begin
            pf    <= base[FW-1:0];
            state <= S_PUSH1;
          end
        end
        S_MRGTST: begin
          if (head_match) begin
            if (XW'(uf) < base) base <= XW'(uf);
            cur_ord <= cur_ord + ORDER_W'(1);
            state   <= S_MRGCHK;
          end else begin
            pf    <= base[FW-1:0];
            state <= S_PUSH1;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          refs  <= ref_rd + REF_W'(1);
          state <= S_DONE;
        end
        S_REFRD: begin
          state <= S_REFWT;
        end
        S_REFWT: begin
          refs  <= ref_rd;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            o_status   <= st;
            o_result   <= res;
            o_released <= rel;
            o_refs     <= refs;
            o_free     <= free_total;
            o_usable   <= usable_total;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = state == S_IDLE;
  assign rsp.valid         = out_valid;
  assign rsp.status        = o_status;
  assign rsp.result_frame  = o_result;
  assign rsp.released      = o_released;
  assign rsp.frame_refs    = o_refs;
  assign rsp.free_count    = o_free;
  assign rsp.usable_frames = o_usable;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_START))
    else $error("accepted transaction did not start");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !rsp.ready) |=> (state == S_DONE && out_valid))
    else $error("pending response overwritten");

  a_alloc_refs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && mode_q == MODE_ALLOC && st == ST_OK) |-> (refs == REF_W'(1)))
    else $error("allocated frame refcount not one");

  a_rel_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rel) |-> (mode_q == MODE_FREE || mode_q == MODE_ADD))
    else $error("release flagged for wrong mode");

endmodule

`default_nettype wire

// File: rtl/core/bfa_ram.sv
// bfa_ram: generic single write port, single read port ram with registered read.
// No dependencies.
`default_nettype none

module bfa_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [W-1:0]                           wd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic [W-1:0]                           rd
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// File: rtl/core/bfa_heads.sv
// bfa_heads: free list head registers, one per order, with the search for the
// smallest non-empty list at or above a requested order. Depends on bfa_pkg.
`default_nettype none

module bfa_heads #(
  parameter int FW        = 16,
  parameter int MAX_ORDER = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [bfa_pkg::ORDER_W-1:0]  idx,
  input  logic [FW:0]                  wdata,
  output logic [FW:0]                  rdata,
  input  logic [bfa_pkg::ORDER_W-1:0]  req_ord,
  output bfa_pkg::head_srch_t          srch
);
  import bfa_pkg::*;

  localparam int NL = MAX_ORDER + 1;
  localparam int OW = (NL > 1) ? $clog2(NL) : 1;
  localparam int LW = FW + 1;

  logic [LW-1:0] head [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NL; i++) begin
        head[i] <= {1'b1, {FW{1'b0}}};
      end
    end else if (we) begin
      head[idx[OW-1:0]] <= wdata;
    end
  end

  assign rdata = head[idx[OW-1:0]];

  always_comb begin
    srch = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (ORDER_W'(i) >= req_ord && !head[i][LW-1]) begin
        srch.any   = 1'b1;
        srch.found = ORDER_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
